// ===== rtl/rvdec_pkg.sv =====
// ----------------------------------------------------------------------------
// rvdec_pkg
// Opcodes, format and mnemonic codes, and funct3 lookup functions for the
// RV64I instruction decoder.
// ----------------------------------------------------------------------------
package rvdec_pkg;

  // Major opcodes
  localparam logic [6:0] OP_R     = 7'b0110011;
  localparam logic [6:0] OP_IARI  = 7'b0010011;
  localparam logic [6:0] OP_LOAD  = 7'b0000011;
  localparam logic [6:0] OP_JALR  = 7'b1100111;
  localparam logic [6:0] OP_STORE = 7'b0100011;
  localparam logic [6:0] OP_BR    = 7'b1100011;
  localparam logic [6:0] OP_JAL   = 7'b1101111;
  localparam logic [6:0] OP_LUI   = 7'b0110111;

  // funct7 values
  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;

  // funct3 values that select special cases
  localparam logic [2:0] F3_ADD = 3'b000;
  localparam logic [2:0] F3_SR  = 3'b101;

  // Instruction formats
  localparam logic [2:0] FMT_R = 3'd0;
  localparam logic [2:0] FMT_I = 3'd1;
  localparam logic [2:0] FMT_S = 3'd2;
  localparam logic [2:0] FMT_B = 3'd3;
  localparam logic [2:0] FMT_J = 3'd4;
  localparam logic [2:0] FMT_U = 3'd5;

  // Mnemonic codes
  localparam logic [5:0] MN_ADD  = 6'd0;
  localparam logic [5:0] MN_SUB  = 6'd1;
  localparam logic [5:0] MN_SLL  = 6'd2;
  localparam logic [5:0] MN_XOR  = 6'd3;
  localparam logic [5:0] MN_SRL  = 6'd4;
  localparam logic [5:0] MN_SRA  = 6'd5;
  localparam logic [5:0] MN_OR   = 6'd6;
  localparam logic [5:0] MN_AND  = 6'd7;
  localparam logic [5:0] MN_ADDI = 6'd8;
  localparam logic [5:0] MN_XORI = 6'd9;
  localparam logic [5:0] MN_ORI  = 6'd10;
  localparam logic [5:0] MN_ANDI = 6'd11;
  localparam logic [5:0] MN_SLLI = 6'd12;
  localparam logic [5:0] MN_SRLI = 6'd13;
  localparam logic [5:0] MN_SRAI = 6'd14;
  localparam logic [5:0] MN_LB   = 6'd15;
  localparam logic [5:0] MN_LH   = 6'd16;
  localparam logic [5:0] MN_LW   = 6'd17;
  localparam logic [5:0] MN_LD   = 6'd18;
  localparam logic [5:0] MN_LBU  = 6'd19;
  localparam logic [5:0] MN_LHU  = 6'd20;
  localparam logic [5:0] MN_LWU  = 6'd21;
  localparam logic [5:0] MN_JALR = 6'd22;
  localparam logic [5:0] MN_SB   = 6'd23;
  localparam logic [5:0] MN_SH   = 6'd24;
  localparam logic [5:0] MN_SW   = 6'd25;
  localparam logic [5:0] MN_SD   = 6'd26;
  localparam logic [5:0] MN_BEQ  = 6'd27;
  localparam logic [5:0] MN_BNE  = 6'd28;
  localparam logic [5:0] MN_BLT  = 6'd29;
  localparam logic [5:0] MN_BGE  = 6'd30;
  localparam logic [5:0] MN_BLTU = 6'd31;
  localparam logic [5:0] MN_BGEU = 6'd32;
  localparam logic [5:0] MN_JAL  = 6'd33;
  localparam logic [5:0] MN_LUI  = 6'd34;
  localparam logic [5:0] MN_MAX  = MN_LUI;

  // Result of a funct3 lookup
  typedef struct packed {
    logic       hit;
    logic [5:0] code;
  } mn_lookup_t;

  // Register-register ops with funct7 zero
  function automatic mn_lookup_t r_base_lookup(input logic [2:0] f3);
    mn_lookup_t r;
    r = '{hit: 1'b1, code: MN_ADD};
    case (f3)
      3'd0: r.code = MN_ADD;
      3'd1: r.code = MN_SLL;
      3'd4: r.code = MN_XOR;
      3'd5: r.code = MN_SRL;
      3'd6: r.code = MN_OR;
      3'd7: r.code = MN_AND;
      default: r = '{hit: 1'b0, code: MN_ADD};
    endcase
    return r;
  endfunction

  // Register-immediate ops; srai is resolved by the caller
  function automatic mn_lookup_t i_arith_lookup(input logic [2:0] f3);
    mn_lookup_t r;
    r = '{hit: 1'b1, code: MN_ADDI};
    case (f3)
      3'd0: r.code = MN_ADDI;
      3'd1: r.code = MN_SLLI;
      3'd4: r.code = MN_XORI;
      3'd5: r.code = MN_SRLI;
      3'd6: r.code = MN_ORI;
      3'd7: r.code = MN_ANDI;
      default: r = '{hit: 1'b0, code: MN_ADDI};
    endcase
    return r;
  endfunction

  // Loads
  function automatic mn_lookup_t i_load_lookup(input logic [2:0] f3);
    mn_lookup_t r;
    r = '{hit: 1'b1, code: MN_LB};
    case (f3)
      3'd0: r.code = MN_LB;
      3'd1: r.code = MN_LH;
      3'd2: r.code = MN_LW;
      3'd3: r.code = MN_LD;
      3'd4: r.code = MN_LBU;
      3'd6: r.code = MN_LHU;
      3'd7: r.code = MN_LWU;
      default: r = '{hit: 1'b0, code: MN_LB};
    endcase
    return r;
  endfunction

  // Stores
  function automatic mn_lookup_t s_store_lookup(input logic [2:0] f3);
    mn_lookup_t r;
    r = '{hit: 1'b1, code: MN_SB};
    case (f3)
      3'd0: r.code = MN_SB;
      3'd1: r.code = MN_SH;
      3'd2: r.code = MN_SW;
      3'd3: r.code = MN_SD;
      default: r = '{hit: 1'b0, code: MN_SB};
    endcase
    return r;
  endfunction

  // Conditional branches
  function automatic mn_lookup_t b_br_lookup(input logic [2:0] f3);
    mn_lookup_t r;
    r = '{hit: 1'b1, code: MN_BEQ};
    case (f3)
      3'd0: r.code = MN_BEQ;
      3'd1: r.code = MN_BNE;
      3'd4: r.code = MN_BLT;
      3'd5: r.code = MN_BGE;
      3'd6: r.code = MN_BLTU;
      3'd7: r.code = MN_BGEU;
      default: r = '{hit: 1'b0, code: MN_BEQ};
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/riscv_instruction_decoder_top.sv =====
// ----------------------------------------------------------------------------
// riscv_instruction_decoder_top
// Decodes one RV64I instruction word per request into format, mnemonic,
// register numbers, sign-extended immediate and branch/jump target.
//
//   channel   handshake          payload
//   --------  -----------------  --------------------------------------------
//   request   start / busy       instr_word, pc_value
//   result    done (1 cycle)     known, format, mnemonic, dest_reg, src1_reg,
//                                src2_reg, immediate, target_addr
//
// A request is taken whenever start is high; busy is always low.
// A request passes through the input register, then through the decode
// logic and the 32-bit target adder into the result register.
// Throughput is one request per cycle, set by that single decode stage.
// Reset clears the pipeline valid flags; requests in flight are dropped.
// Results are shown for one cycle with done; the receiver cannot stall.
// ----------------------------------------------------------------------------
module riscv_instruction_decoder_top
  import rvdec_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        instr_word,
  input  logic [31:0]        pc_value,
  output logic               done,
  output logic               known,
  output logic [2:0]         format,
  output logic [5:0]         mnemonic,
  output logic [4:0]         dest_reg,
  output logic [4:0]         src1_reg,
  output logic [4:0]         src2_reg,
  output logic signed [31:0] immediate,
  output logic [31:0]        target_addr
);

  // Input register
  logic        in_valid;
  logic [31:0] in_word;
  logic [31:0] in_pc;

  // Never stall requests
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_word <= instr_word;
      in_pc   <= pc_value;
    end
  end

  // Instruction fields
  logic [6:0]  op;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [4:0]  rs1;
  logic [4:0]  rs2;
  logic [6:0]  f7;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] imm_u;

  assign op  = in_word[6:0];
  assign rd  = in_word[11:7];
  assign f3  = in_word[14:12];
  assign rs1 = in_word[19:15];
  assign rs2 = in_word[24:20];
  assign f7  = in_word[31:25];

  assign imm_i = {{20{in_word[31]}}, in_word[31:20]};
  assign imm_s = {{20{in_word[31]}}, in_word[31:25], in_word[11:7]};
  assign imm_b = {{20{in_word[31]}}, in_word[7], in_word[30:25], in_word[11:8], 1'b0};
  assign imm_j = {{12{in_word[31]}}, in_word[19:12], in_word[20], in_word[30:21], 1'b0};
  assign imm_u = {in_word[31:12], 12'b0};

  // Decode next result
  mn_lookup_t  lk;
  logic        known_next;
  logic [2:0]  format_next;
  logic [5:0]  mnemonic_next;
  logic [4:0]  dest_next;
  logic [4:0]  src1_next;
  logic [4:0]  src2_next;
  logic [31:0] imm_next;
  logic        use_target;
  logic [31:0] target_next;

  always_comb begin
    lk          = '{hit: 1'b0, code: MN_ADD};
    format_next = FMT_R;
    dest_next   = '0;
    src1_next   = '0;
    src2_next   = '0;
    imm_next    = '0;
    use_target  = 1'b0;
    case (op)
      OP_R: begin
        format_next = FMT_R;
        dest_next   = rd;
        src1_next   = rs1;
        src2_next   = rs2;
        if (f7 == F7_BASE) begin
          lk = r_base_lookup(f3);
        end else if (f7 == F7_ALT && f3 == F3_ADD) begin
          lk = '{hit: 1'b1, code: MN_SUB};
        end else if (f7 == F7_ALT && f3 == F3_SR) begin
          lk = '{hit: 1'b1, code: MN_SRA};
        end
      end
      OP_IARI: begin
        format_next = FMT_I;
        dest_next   = rd;
        src1_next   = rs1;
        imm_next    = imm_i;
        lk          = i_arith_lookup(f3);
        if (f3 == F3_SR && in_word[30]) begin
          lk = '{hit: 1'b1, code: MN_SRAI};
        end
      end
      OP_LOAD: begin
        format_next = FMT_I;
        dest_next   = rd;
        src1_next   = rs1;
        imm_next    = imm_i;
        lk          = i_load_lookup(f3);
      end
      OP_JALR: begin
        format_next = FMT_I;
        dest_next   = rd;
        src1_next   = rs1;
        imm_next    = imm_i;
        lk          = '{hit: (f3 == F3_ADD), code: MN_JALR};
      end
      OP_STORE: begin
        format_next = FMT_S;
        src1_next   = rs1;
        src2_next   = rs2;
        imm_next    = imm_s;
        lk          = s_store_lookup(f3);
      end
      OP_BR: begin
        format_next = FMT_B;
        src1_next   = rs1;
        src2_next   = rs2;
        imm_next    = imm_b;
        use_target  = 1'b1;
        lk          = b_br_lookup(f3);
      end
      OP_JAL: begin
        format_next = FMT_J;
        dest_next   = rd;
        imm_next    = imm_j;
        use_target  = 1'b1;
        lk          = '{hit: 1'b1, code: MN_JAL};
      end
      OP_LUI: begin
        format_next = FMT_U;
        dest_next   = rd;
        imm_next    = imm_u;
        lk          = '{hit: 1'b1, code: MN_LUI};
      end
      default: begin
        lk = '{hit: 1'b0, code: MN_ADD};
      end
    endcase

    // Target wraps modulo 2^32
    target_next = use_target ? (in_pc + imm_next) : '0;

    // Drop every field of an unrecognized encoding
    known_next    = lk.hit;
    mnemonic_next = lk.code;
    if (!lk.hit) begin
      format_next   = '0;
      mnemonic_next = '0;
      dest_next     = '0;
      src1_next     = '0;
      src2_next     = '0;
      imm_next      = '0;
      target_next   = '0;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (in_valid) begin
      known       <= known_next;
      format      <= format_next;
      mnemonic    <= mnemonic_next;
      dest_reg    <= dest_next;
      src1_reg    <= src1_next;
      src2_reg    <= src2_next;
      immediate   <= imm_next;
      target_addr <= target_next;
    end
  end

  // A request always yields a done strobe through the input and result registers
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("request did not produce a result");

  // Unknown encodings carry all-zero fields
  assert property (@(posedge clk) disable iff (rst)
    (done && !known) |-> (format == '0 && mnemonic == '0 && dest_reg == '0 &&
                          src1_reg == '0 && src2_reg == '0 && immediate == '0 &&
                          target_addr == '0))
    else $error("unknown encoding with nonzero fields");

  // Known results stay within the code ranges
  assert property (@(posedge clk) disable iff (rst)
    (done && known) |-> (mnemonic <= MN_MAX && format <= FMT_U))
    else $error("mnemonic or format out of range");

  // Only branches and jal carry a target
  assert property (@(posedge clk) disable iff (rst)
    (done && target_addr != '0) |-> (format == FMT_B || format == FMT_J))
    else $error("target on a non-branch result");

  // Branch and jump immediates are even
  assert property (@(posedge clk) disable iff (rst)
    (done && (format == FMT_B || format == FMT_J)) |-> (immediate[0] == 1'b0))
    else $error("odd branch or jump offset");

endmodule

// ===== test/tb_riscv_instruction_decoder_top.sv =====
// ----------------------------------------------------------------------------
// tb_riscv_instruction_decoder_top
// Self-checking bench for the RV64I instruction decoder. A directed set of
// edge encodings is followed by 2000 random requests. Most of them are
// well-formed instructions with random fields; the rest are raw words and
// known opcodes with random funct bits. Each accepted request is decoded by
// a local predictor, and every done strobe is checked field by field
// against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_riscv_instruction_decoder_top;
  import rvdec_pkg::*;

  localparam int         RANDOM_REQUESTS = 2000;
  localparam int         CALM_TAIL       = 200;
  localparam int         DRAIN_CYCLES    = 8;
  localparam int         WATCHDOG_LIMIT  = 1000;
  localparam logic [6:0] OP_AUIPC        = 7'b0010111;

  typedef struct packed {
    logic [31:0] instr;
    logic [31:0] pc;
  } request_t;

  typedef struct packed {
    logic        known;
    logic [2:0]  format;
    logic [5:0]  mnemonic;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic [31:0] immediate;
    logic [31:0] target_addr;
  } decoded_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [31:0]        instr_word = '0;
  logic [31:0]        pc_value = '0;
  logic               busy;
  logic               done;
  logic               known;
  logic [2:0]         format;
  logic [5:0]         mnemonic;
  logic [4:0]         dest_reg;
  logic [4:0]         src1_reg;
  logic [4:0]         src2_reg;
  logic signed [31:0] immediate;
  logic [31:0]        target_addr;

  request_t pending_q[$];
  decoded_t decoded_q[$];
  int       fail_count = 0;
  int       gap_left = 0;
  int       gap_pct = 0;
  int       issued = 0;
  int       idle_cycles = 0;

  riscv_instruction_decoder_top dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .instr_word (instr_word),
    .pc_value   (pc_value),
    .done       (done),
    .known      (known),
    .format     (format),
    .mnemonic   (mnemonic),
    .dest_reg   (dest_reg),
    .src1_reg   (src1_reg),
    .src2_reg   (src2_reg),
    .immediate  (immediate),
    .target_addr(target_addr)
  );

  always #1 clk = ~clk;

  // Decode one instruction word the way the block should
  function automatic decoded_t decode_instr(input logic [31:0] w, input logic [31:0] pc);
    decoded_t    r;
    logic [6:0]  opc;
    logic [6:0]  f7;
    logic [2:0]  f3;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic        hit;
    logic [5:0]  code;
    r     = '0;
    hit   = 1'b0;
    code  = MN_ADD;
    opc   = w[6:0];
    f3    = w[14:12];
    f7    = w[31:25];
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    case (opc)
      OP_R: begin
        r.format = FMT_R;
        r.dest_reg = w[11:7];
        r.src1_reg = w[19:15];
        r.src2_reg = w[24:20];
        if (f7 == F7_BASE) begin
          hit = 1'b1;
          case (f3)
            3'd0: code = MN_ADD;
            3'd1: code = MN_SLL;
            3'd4: code = MN_XOR;
            3'd5: code = MN_SRL;
            3'd6: code = MN_OR;
            3'd7: code = MN_AND;
            default: hit = 1'b0;
          endcase
        end else if (f7 == F7_ALT && f3 == F3_ADD) begin
          hit = 1'b1;
          code = MN_SUB;
        end else if (f7 == F7_ALT && f3 == F3_SR) begin
          hit = 1'b1;
          code = MN_SRA;
        end
      end
      OP_IARI: begin
        r.format = FMT_I;
        r.dest_reg = w[11:7];
        r.src1_reg = w[19:15];
        r.immediate = imm_i;
        hit = 1'b1;
        // slli ignores the upper bits; right shifts split on bit 30
        case (f3)
          3'd0: code = MN_ADDI;
          3'd1: code = MN_SLLI;
          3'd4: code = MN_XORI;
          3'd5: code = w[30] ? MN_SRAI : MN_SRLI;
          3'd6: code = MN_ORI;
          3'd7: code = MN_ANDI;
          default: hit = 1'b0;
        endcase
      end
      OP_LOAD: begin
        r.format = FMT_I;
        r.dest_reg = w[11:7];
        r.src1_reg = w[19:15];
        r.immediate = imm_i;
        hit = 1'b1;
        case (f3)
          3'd0: code = MN_LB;
          3'd1: code = MN_LH;
          3'd2: code = MN_LW;
          3'd3: code = MN_LD;
          3'd4: code = MN_LBU;
          3'd6: code = MN_LHU;
          3'd7: code = MN_LWU;
          default: hit = 1'b0;
        endcase
      end
      OP_JALR: begin
        r.format = FMT_I;
        r.dest_reg = w[11:7];
        r.src1_reg = w[19:15];
        r.immediate = imm_i;
        hit = (f3 == F3_ADD);
        code = MN_JALR;
      end
      OP_STORE: begin
        r.format = FMT_S;
        r.src1_reg = w[19:15];
        r.src2_reg = w[24:20];
        r.immediate = imm_s;
        hit = 1'b1;
        case (f3)
          3'd0: code = MN_SB;
          3'd1: code = MN_SH;
          3'd2: code = MN_SW;
          3'd3: code = MN_SD;
          default: hit = 1'b0;
        endcase
      end
      OP_BR: begin
        r.format = FMT_B;
        r.src1_reg = w[19:15];
        r.src2_reg = w[24:20];
        r.immediate = imm_b;
        r.target_addr = pc + imm_b;
        hit = 1'b1;
        case (f3)
          3'd0: code = MN_BEQ;
          3'd1: code = MN_BNE;
          3'd4: code = MN_BLT;
          3'd5: code = MN_BGE;
          3'd6: code = MN_BLTU;
          3'd7: code = MN_BGEU;
          default: hit = 1'b0;
        endcase
      end
      OP_JAL: begin
        r.format = FMT_J;
        r.dest_reg = w[11:7];
        r.immediate = imm_j;
        r.target_addr = pc + imm_j;
        hit = 1'b1;
        code = MN_JAL;
      end
      OP_LUI: begin
        r.format = FMT_U;
        r.dest_reg = w[11:7];
        r.immediate = {w[31:12], 12'h000};
        hit = 1'b1;
        code = MN_LUI;
      end
      default: hit = 1'b0;
    endcase
    // Unrecognized encodings clear every field
    if (!hit) begin
      r = '0;
    end else begin
      r.known = 1'b1;
      r.mnemonic = code;
    end
    return r;
  endfunction

  // Build a well-formed word for one mnemonic with random other bits
  function automatic logic [31:0] encode_mnemonic(input logic [5:0] mn);
    logic [31:0] w;
    logic [6:0]  opc;
    logic [2:0]  f3;
    w   = $urandom;
    f3  = w[14:12];
    opc = OP_LUI;
    case (mn)
      MN_ADD:  begin opc = OP_R;     f3 = 3'd0; end
      MN_SUB:  begin opc = OP_R;     f3 = 3'd0; end
      MN_SLL:  begin opc = OP_R;     f3 = 3'd1; end
      MN_XOR:  begin opc = OP_R;     f3 = 3'd4; end
      MN_SRL:  begin opc = OP_R;     f3 = 3'd5; end
      MN_SRA:  begin opc = OP_R;     f3 = 3'd5; end
      MN_OR:   begin opc = OP_R;     f3 = 3'd6; end
      MN_AND:  begin opc = OP_R;     f3 = 3'd7; end
      MN_ADDI: begin opc = OP_IARI;  f3 = 3'd0; end
      MN_XORI: begin opc = OP_IARI;  f3 = 3'd4; end
      MN_ORI:  begin opc = OP_IARI;  f3 = 3'd6; end
      MN_ANDI: begin opc = OP_IARI;  f3 = 3'd7; end
      MN_SLLI: begin opc = OP_IARI;  f3 = 3'd1; end
      MN_SRLI: begin opc = OP_IARI;  f3 = 3'd5; end
      MN_SRAI: begin opc = OP_IARI;  f3 = 3'd5; end
      MN_LB:   begin opc = OP_LOAD;  f3 = 3'd0; end
      MN_LH:   begin opc = OP_LOAD;  f3 = 3'd1; end
      MN_LW:   begin opc = OP_LOAD;  f3 = 3'd2; end
      MN_LD:   begin opc = OP_LOAD;  f3 = 3'd3; end
      MN_LBU:  begin opc = OP_LOAD;  f3 = 3'd4; end
      MN_LHU:  begin opc = OP_LOAD;  f3 = 3'd6; end
      MN_LWU:  begin opc = OP_LOAD;  f3 = 3'd7; end
      MN_JALR: begin opc = OP_JALR;  f3 = 3'd0; end
      MN_SB:   begin opc = OP_STORE; f3 = 3'd0; end
      MN_SH:   begin opc = OP_STORE; f3 = 3'd1; end
      MN_SW:   begin opc = OP_STORE; f3 = 3'd2; end
      MN_SD:   begin opc = OP_STORE; f3 = 3'd3; end
      MN_BEQ:  begin opc = OP_BR;    f3 = 3'd0; end
      MN_BNE:  begin opc = OP_BR;    f3 = 3'd1; end
      MN_BLT:  begin opc = OP_BR;    f3 = 3'd4; end
      MN_BGE:  begin opc = OP_BR;    f3 = 3'd5; end
      MN_BLTU: begin opc = OP_BR;    f3 = 3'd6; end
      MN_BGEU: begin opc = OP_BR;    f3 = 3'd7; end
      MN_JAL:  opc = OP_JAL;
      default: opc = OP_LUI;
    endcase
    w[6:0]   = opc;
    w[14:12] = f3;
    if (opc == OP_R) begin
      w[31:25] = (mn == MN_SUB || mn == MN_SRA) ? F7_ALT : F7_BASE;
    end
    if (mn == MN_SRLI) w[30] = 1'b0;
    if (mn == MN_SRAI) w[30] = 1'b1;
    return w;
  endfunction

  // Mostly legal instructions, some raw noise and broken funct fields
  function automatic request_t random_request();
    request_t req;
    int       sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) begin
      req.instr = encode_mnemonic(6'($urandom_range(0, MN_MAX)));
    end else if (sel < 90) begin
      req.instr = $urandom;
    end else begin
      req.instr = $urandom;
      case ($urandom_range(0, 7))
        0: req.instr[6:0] = OP_R;
        1: req.instr[6:0] = OP_IARI;
        2: req.instr[6:0] = OP_LOAD;
        3: req.instr[6:0] = OP_JALR;
        4: req.instr[6:0] = OP_STORE;
        5: req.instr[6:0] = OP_BR;
        6: req.instr[6:0] = OP_JAL;
        default: req.instr[6:0] = OP_LUI;
      endcase
    end
    // Bias pc toward both ends so targets wrap
    case ($urandom_range(0, 9))
      0: req.pc = $urandom_range(0, 4095);
      1: req.pc = 32'hFFFF_F000 | $urandom_range(0, 4095);
      default: req.pc = $urandom;
    endcase
    return req;
  endfunction

  task automatic add_request(input logic [31:0] w, input logic [31:0] pc);
    pending_q.push_back('{instr: w, pc: pc});
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Driver: issue pending requests, predict each one as it is accepted
  always @(posedge clk) begin : driver
    request_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // hold the request until it is taken
    end else begin
      if (start) begin
        decoded_q.push_back(decode_instr(instr_word, pc_value));
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_q.size() > 0) begin
        nxt = pending_q.pop_front();
        instr_word <= nxt.instr;
        pc_value <= nxt.pc;
        start <= 1'b1;
        if (issued % 128 == 0) begin
          case ($urandom_range(0, 2))
            0: gap_pct = 0;
            1: gap_pct = 6;
            default: gap_pct = 30;
          endcase
        end
        issued++;
        if (pending_q.size() >= CALM_TAIL && $urandom_range(0, 99) < gap_pct) begin
          gap_left = $urandom_range(1, 15);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each result with the oldest prediction
  always @(posedge clk) begin : monitor
    decoded_t exp_r;
    if (!rst && done) begin
      if (decoded_q.size() == 0) begin
        $error("result with no request outstanding: mnemonic %0d", mnemonic);
        fail_count++;
      end else begin
        exp_r = decoded_q.pop_front();
        check_field("known", 32'(exp_r.known), 32'(known));
        check_field("format", 32'(exp_r.format), 32'(format));
        check_field("mnemonic", 32'(exp_r.mnemonic), 32'(mnemonic));
        check_field("dest_reg", 32'(exp_r.dest_reg), 32'(dest_reg));
        check_field("src1_reg", 32'(exp_r.src1_reg), 32'(src1_reg));
        check_field("src2_reg", 32'(exp_r.src2_reg), 32'(src2_reg));
        check_field("immediate", exp_r.immediate, immediate);
        check_field("target_addr", exp_r.target_addr, target_addr);
      end
    end
  end

  // Watchdog: abort when nothing moves for too long
  always @(posedge clk) begin : watchdog
    if (rst || (start && !busy) || done) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    // Extremes of the word and pc, unknown opcodes
    add_request(32'h0000_0000, 32'h0000_0000);
    add_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_request({20'hABCDE, 5'd7, OP_AUIPC}, 32'h0000_1000);
    // Register ops: base, alternate funct7, illegal combinations
    add_request({F7_BASE, 5'd0, 5'd0, F3_ADD, 5'd0, OP_R}, 32'h0000_0000);
    add_request({F7_ALT, 5'd31, 5'd31, F3_ADD, 5'd31, OP_R}, 32'hFFFF_FFFF);
    add_request({F7_ALT, 5'd1, 5'd2, F3_SR, 5'd3, OP_R}, 32'h1234_5678);
    add_request({F7_ALT, 5'd4, 5'd5, 3'd1, 5'd6, OP_R}, 32'h0000_0040);
    add_request({F7_BASE, 5'd4, 5'd5, 3'd2, 5'd6, OP_R}, 32'h0000_0080);
    // Immediate ops: sign extremes, shift special cases
    add_request({12'hFFF, 5'd31, F3_ADD, 5'd31, OP_IARI}, 32'h0000_0100);
    add_request({12'h7FF, 5'd1, F3_ADD, 5'd2, OP_IARI}, 32'h0000_0104);
    add_request({F7_ALT, 5'd7, 5'd8, 3'd1, 5'd9, OP_IARI}, 32'h0000_0108);
    add_request({F7_BASE, 5'd31, 5'd1, F3_SR, 5'd2, OP_IARI}, 32'h0000_010C);
    add_request({F7_ALT, 5'd5, 5'd1, F3_SR, 5'd2, OP_IARI}, 32'h0000_0110);
    add_request({7'b1100000, 5'd5, 5'd1, F3_SR, 5'd2, OP_IARI}, 32'h0000_0114);
    add_request({12'h123, 5'd1, 3'd2, 5'd2, OP_IARI}, 32'h0000_0118);
    // Loads and jalr
    add_request({12'h800, 5'd10, 3'd3, 5'd11, OP_LOAD}, 32'h0000_0200);
    add_request({12'h001, 5'd10, 3'd5, 5'd11, OP_LOAD}, 32'h0000_0204);
    add_request({12'h800, 5'd1, F3_ADD, 5'd31, OP_JALR}, 32'h0000_0208);
    add_request({12'h010, 5'd1, 3'd1, 5'd31, OP_JALR}, 32'h0000_020C);
    // Stores
    add_request({7'h7F, 5'd31, 5'd31, 3'd3, 5'd31, OP_STORE}, 32'h0000_0300);
    add_request({7'h01, 5'd2, 5'd3, 3'd4, 5'd4, OP_STORE}, 32'h0000_0304);
    // Branches: most negative offset wraps below zero, largest wraps above
    add_request({1'b1, 6'd0, 5'd1, 5'd2, F3_ADD, 4'd0, 1'b0, OP_BR}, 32'h0000_0000);
    add_request({1'b0, 6'h3F, 5'd3, 5'd4, 3'd7, 4'hF, 1'b1, OP_BR}, 32'hFFFF_F800);
    add_request({1'b0, 6'h01, 5'd3, 5'd4, 3'd2, 4'h1, 1'b0, OP_BR}, 32'h0000_0400);
    // jal: low offset bit forced to zero, all-ones and largest positive offsets
    add_request({25'h1FF_FFFF, OP_JAL}, 32'h0000_0000);
    add_request({1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd31, OP_JAL}, 32'hFFFF_FFFF);
    // lui with every upper bit set
    add_request({20'hFFFFF, 5'd31, OP_LUI}, 32'h0000_0500);

    repeat (RANDOM_REQUESTS) pending_q.push_back(random_request());

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Wait for the last request to be taken and its result to come back
    while (pending_q.size() > 0 || start || decoded_q.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
